// ===== hw/rtl/feedback_echo_delay_assert.svh =====
// Assertion macros shared by the echo delay RTL.
`ifndef FEEDBACK_ECHO_DELAY_ASSERT_SVH
`define FEEDBACK_ECHO_DELAY_ASSERT_SVH

// Checked on every clock edge outside reset.
`define FED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define FED_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/fed_pkg.sv =====
package fed_pkg;

  // Delay store geometry
  localparam int DEPTH       = 131072;
  localparam int ADDR_BITS   = $clog2(DEPTH);
  localparam int SAMPLE_BITS = 16;

  // Register field widths
  localparam int DLY_BITS      = 17;
  localparam int FB_BITS       = 15;
  localparam int WET_BITS      = 16;
  localparam int CFG_DATA_BITS = 17;
  localparam int CFG_IDX_BITS  = 2;

  // Q1.15 gains
  localparam int GAIN_FRAC = 15;
  localparam logic [DLY_BITS-1:0] DELAY_RST = DLY_BITS'(24000);
  localparam logic [FB_BITS-1:0]  FB_CAP    = FB_BITS'(29491);
  localparam logic [WET_BITS-1:0] WET_ONE   = WET_BITS'(32768);
  localparam logic [WET_BITS-1:0] WET_MIN   = WET_BITS'(33);

  // Datapath widths: sample times a 17-bit signed gain, and the saturator input
  localparam int PROD_BITS   = SAMPLE_BITS + WET_BITS + 1;
  localparam int MIX_BITS    = PROD_BITS + 1;
  localparam int SAT_IN_BITS = SAMPLE_BITS + 2;

  localparam logic [ADDR_BITS-1:0] WI_LAST   = ADDR_BITS'(DEPTH - 1);
  localparam logic [ADDR_BITS:0]   DEPTH_EXT = (ADDR_BITS + 1)'(DEPTH);

  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DELAY    = 2'd0,
    CFG_FEEDBACK = 2'd1,
    CFG_WET      = 2'd2
  } cfg_idx_e;

  // Clamp a widened value to the signed sample range
  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [SAT_IN_BITS-1:0] v
  );
    logic signed [SAT_IN_BITS-1:0] hi;
    logic signed [SAT_IN_BITS-1:0] lo;
    hi = SAT_IN_BITS'(SMP_MAX);
    lo = SAT_IN_BITS'(SMP_MIN);
    if (v > hi) begin
      return SMP_MAX;
    end else if (v < lo) begin
      return SMP_MIN;
    end else begin
      return v[SAMPLE_BITS-1:0];
    end
  endfunction

endpackage

// ===== hw/rtl/feedback_echo_delay.sv =====
// Path: an accepted item passes stage 1, stage 2, stage 3 and the output register in turn.
// Throughput: one item per cycle while the output is not stalled; the feedback loop (read,
// scale, add, write back) closes through forwarding around the single-port-pair delay memory.
// A stalled output freezes the whole pipeline; input ready follows it.
// Reset: registers take their defaults, write index zero; store entries not yet written
// read as zero (tracked with a wrap flag), so no clearing pass is run.
`include "feedback_echo_delay_assert.svh"

module feedback_echo_delay
  import fed_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data_i,
  // Input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_i,
  input  logic                          block_end_i,
  // Result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] out_sample_o,
  output logic                          block_end_out_o
);

  // Configuration registers
  logic [DLY_BITS-1:0] dly_q, dly_d;
  logic [FB_BITS-1:0]  fb_q, fb_d;
  logic [WET_BITS-1:0] wet_q, wet_d;

  // Clamped settings
  logic [ADDR_BITS-1:0] dly_cl;
  logic [FB_BITS-1:0]   fb_cl;
  logic [WET_BITS-1:0]  wet_cl;
  logic [WET_BITS-1:0]  dry_gain;
  logic                 bypass;

  // Write pointer
  logic [ADDR_BITS-1:0] wi_q, wi_d;
  logic                 wrapped_q, wrapped_d;
  logic [ADDR_BITS-1:0] ri;
  logic                 ent_vld;

  logic advance;
  logic accept;

  // Stage 1: read data arrives
  logic                          s1_vld_q;
  logic signed [SAMPLE_BITS-1:0] s1_x_q;
  logic                          s1_be_q;
  logic                          s1_byp_q;
  logic                          s1_ent_vld_q;
  logic [ADDR_BITS-1:0]          s1_ri_q;
  logic [ADDR_BITS-1:0]          s1_wi_q;
  logic signed [SAMPLE_BITS-1:0] s1_d;

  // Stage 2: feedback write and mix products
  logic                          s2_vld_q;
  logic signed [SAMPLE_BITS-1:0] s2_x_q;
  logic signed [SAMPLE_BITS-1:0] s2_d_q;
  logic                          s2_be_q;
  logic                          s2_byp_q;
  logic [ADDR_BITS-1:0]          s2_wi_q;
  logic signed [PROD_BITS-1:0]   fb_prod;
  logic signed [PROD_BITS-1:0]   fb_sh;
  logic signed [SAT_IN_BITS-1:0] w_sum;
  logic signed [SAMPLE_BITS-1:0] w_s2;
  logic signed [PROD_BITS-1:0]   pdry;
  logic signed [PROD_BITS-1:0]   pwet;

  // Stage 3: mix sum and round
  logic                          s3_vld_q;
  logic signed [SAMPLE_BITS-1:0] s3_x_q;
  logic                          s3_be_q;
  logic                          s3_byp_q;
  logic signed [PROD_BITS-1:0]   s3_pdry_q;
  logic signed [PROD_BITS-1:0]   s3_pwet_q;
  logic signed [MIX_BITS-1:0]    mix_sum;
  logic signed [MIX_BITS-1:0]    mix_sh;
  logic signed [SAMPLE_BITS-1:0] mix_sat;

  // Output register
  logic                          out_vld_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic                          out_be_q;

  // Last committed write, for the read that collided with it
  logic                          lw_vld_q;
  logic [ADDR_BITS-1:0]          lw_addr_q;
  logic signed [SAMPLE_BITS-1:0] lw_data_q;

  // Memory port
  logic                   ram_we;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  // Configuration write decode
  always_comb begin
    dly_d = dly_q;
    fb_d  = fb_q;
    wet_d = wet_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DELAY:    dly_d = cfg_data_i[DLY_BITS-1:0];
        CFG_FEEDBACK: fb_d  = cfg_data_i[FB_BITS-1:0];
        CFG_WET:      wet_d = cfg_data_i[WET_BITS-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_q <= DELAY_RST;
      fb_q  <= '0;
      wet_q <= '0;
    end else begin
      dly_q <= dly_d;
      fb_q  <= fb_d;
      wet_q <= wet_d;
    end
  end

  // Setting clamps
  always_comb begin
    if (dly_q == '0) begin
      dly_cl = ADDR_BITS'(1);
    end else if (32'(dly_q) >= DEPTH) begin
      dly_cl = WI_LAST;
    end else begin
      dly_cl = ADDR_BITS'(dly_q);
    end
    fb_cl    = (fb_q > FB_CAP) ? FB_CAP : fb_q;
    wet_cl   = (wet_q > WET_ONE) ? WET_ONE : wet_q;
    dry_gain = WET_ONE - wet_cl;
    bypass   = (wet_cl < WET_MIN);
  end

  // Whole pipeline moves when the output register can take an item
  assign advance    = !out_vld_q || out_ready_i;
  assign in_ready_o = advance;
  assign accept     = in_valid_i && advance;

  // Read address; an entry is valid once the pointer has passed it
  always_comb begin
    if (wi_q >= dly_cl) begin
      ri = wi_q - dly_cl;
    end else begin
      ri = ADDR_BITS'(DEPTH_EXT + {1'b0, wi_q} - {1'b0, dly_cl});
    end
    ent_vld = wrapped_q || (wi_q >= dly_cl);
  end

  // Write pointer advance
  always_comb begin
    wi_d      = wi_q;
    wrapped_d = wrapped_q;
    if (accept && !bypass) begin
      if (wi_q == WI_LAST) begin
        wi_d      = '0;
        wrapped_d = 1'b1;
      end else begin
        wi_d = wi_q + ADDR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q      <= '0;
      wrapped_q <= 1'b0;
    end else begin
      wi_q      <= wi_d;
      wrapped_q <= wrapped_d;
    end
  end

  // Delay store
  fed_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s2_wi_q),
    .wdata_i (w_s2),
    .re_i    (advance),
    .raddr_i (ri),
    .rdata_o (ram_rdata)
  );

  // Stage 1 delayed-sample select: newest writer first
  always_comb begin
    if (s2_vld_q && !s2_byp_q && (s2_wi_q == s1_ri_q)) begin
      s1_d = w_s2;
    end else if (lw_vld_q && (lw_addr_q == s1_ri_q)) begin
      s1_d = lw_data_q;
    end else if (s1_ent_vld_q) begin
      s1_d = ram_rdata;
    end else begin
      s1_d = '0;
    end
  end

  // Stage 2: stored value and mix products
  always_comb begin
    fb_prod = PROD_BITS'(s2_d_q) * PROD_BITS'($signed({1'b0, fb_cl}));
    fb_sh   = (fb_prod + PROD_BITS'(1 << (GAIN_FRAC - 1))) >>> GAIN_FRAC;
    w_sum   = SAT_IN_BITS'(s2_x_q) + SAT_IN_BITS'(fb_sh);
    w_s2    = sat_sample(w_sum);
    pdry    = PROD_BITS'(s2_x_q) * PROD_BITS'($signed({1'b0, dry_gain}));
    pwet    = PROD_BITS'(s2_d_q) * PROD_BITS'($signed({1'b0, wet_cl}));
  end

  assign ram_we = advance && s2_vld_q && !s2_byp_q;

  // Stage 3: round and clamp the mix
  always_comb begin
    mix_sum = MIX_BITS'(s3_pdry_q) + MIX_BITS'(s3_pwet_q)
            + MIX_BITS'(1 << (GAIN_FRAC - 1));
    mix_sh  = mix_sum >>> GAIN_FRAC;
    mix_sat = sat_sample(SAT_IN_BITS'(mix_sh));
  end

  // Pipeline valids and last-write tracker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      lw_vld_q  <= 1'b0;
    end else if (advance) begin
      s1_vld_q  <= in_valid_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      out_vld_q <= s3_vld_q;
      lw_vld_q  <= ram_we;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_x_q       <= in_sample_i;
      s1_be_q      <= block_end_i;
      s1_byp_q     <= bypass;
      s1_ent_vld_q <= ent_vld;
      s1_ri_q      <= ri;
      s1_wi_q      <= wi_q;

      s2_x_q   <= s1_x_q;
      s2_d_q   <= s1_d;
      s2_be_q  <= s1_be_q;
      s2_byp_q <= s1_byp_q;
      s2_wi_q  <= s1_wi_q;

      s3_x_q    <= s2_x_q;
      s3_be_q   <= s2_be_q;
      s3_byp_q  <= s2_byp_q;
      s3_pdry_q <= pdry;
      s3_pwet_q <= pwet;

      lw_addr_q <= s2_wi_q;
      lw_data_q <= w_s2;

      out_sample_q <= s3_byp_q ? s3_x_q : mix_sat;
      out_be_q     <= s3_be_q;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign out_sample_o    = out_sample_q;
  assign block_end_out_o = out_be_q;

  // Checks
  `FED_ASSERT(a_lw_tracks_write, ram_we |=> lw_vld_q && (lw_addr_q == $past(s2_wi_q)), "last-write tracker lost a store write")
  `FED_ASSERT(a_valid_entry_behind_ptr, s1_vld_q && s1_ent_vld_q && !wrapped_q |-> s1_ri_q < wi_q, "entry marked written ahead of the write pointer")
  `FED_ASSERT(a_bypass_keeps_ptr, accept && bypass |=> $stable(wi_q) && $stable(wrapped_q), "bypassed item moved the write pointer")
  `FED_ASSERT(a_s3_reaches_out, s3_vld_q && advance |=> out_vld_q, "item dropped between last stage and output")
  `FED_ASSERT_RST(a_reset_clears, !rst_ni |=> !out_valid_o && !lw_vld_q && !s1_vld_q, "pipeline not cleared in reset")

endmodule

// ===== hw/rtl/fed_ram.sv =====
module fed_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, old data on a same-address collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
